@@ design/fdc_pkg.sv @@
// Package: shared types, constants and the CRC-32 byte update for the frame deframer.
package fdc_pkg;

  // Frame layout and defaults
  localparam int HdrBytes    = 32;
  localparam int HdrIdxW     = $clog2(HdrBytes);
  localparam int DefSizeBits = 24;
  localparam int ConsumedW   = 25;
  localparam int FifoDepth   = 4;

  // CRC-32, reflected
  localparam logic [31:0] CrcInit = 32'hffff_ffff;
  localparam logic [31:0] CrcPoly = 32'hedb8_8320;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC       = 2'd0;
  localparam logic [1:0] CFG_VERSION     = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT_HDR,
    ST_BAD_MAGIC,
    ST_BAD_VERSION,
    ST_TOO_LARGE,
    ST_SHORT_PAYLOAD,
    ST_CRC_MISMATCH
  } status_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           payload_byte;
    status_t              status;
    logic [15:0]          msg_type;
    logic [31:0]          msg_flags;
    logic [63:0]          msg_id;
    logic [31:0]          msg_size;
    logic [ConsumedW-1:0] consumed;
    logic                 run_last;
  } result_t;

  // One byte through the reflected CRC, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ design/fdc_in_if.sv @@
// Interface: input byte channel of the frame deframer.
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_buffer;

  modport source (output valid, output byte_in, output end_of_buffer, input ready);
  modport sink   (input valid, input byte_in, input end_of_buffer, output ready);
endinterface

@@ design/fdc_out_if.sv @@
// Interface: result channel of the frame deframer.
interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] msg_type;
  logic [31:0] msg_flags;
  logic [63:0] msg_id;
  logic [31:0] msg_size;
  logic [24:0] consumed;
  logic        run_last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output msg_type, output msg_flags, output msg_id,
                  output msg_size, output consumed, output run_last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input msg_type, input msg_flags, input msg_id,
                  input msg_size, input consumed, input run_last, output ready);
endinterface

@@ design/frame_deframer_crc32_check_top.sv @@
// Top level: length-prefixed frame deframer with payload CRC-32 check.
//
// Usage: bytes of a buffer arrive one per request on in_if, with end_of_buffer
// on the last byte. The first 32 bytes are the little-endian header. Once the
// header is in, magic, version and size limit are checked; payload bytes then
// leave on out_if with kind 0 as they arrive, and one verdict (kind 1) follows
// with the status, header fields and, if OK, the bytes consumed. Bytes after
// the verdict give no result until the end of the buffer, which returns the
// block to the header phase. cfg_we/cfg_index/cfg_wdata set magic, version
// and size limit; the user must do so only while the block is idle, unchecked.
//
// Timing: a byte is registered at acceptance and decoded from the input
// register once the result queue has room; its results are offered from
// the queue. A payload byte that closes the frame makes two results. Input
// is taken while at least two of the four result queue slots are free, so
// with a ready receiver one byte goes in every cycle. When the receiver
// stalls the queue fills and in_if.ready drops; nothing is lost.
// Reset (synchronous, rst_n low) empties the queue, restores the register
// defaults and puts the decoder in the header phase.
module frame_deframer_crc32_check_top
  import fdc_pkg::*;
#(
  parameter int SIZE_BITS = DefSizeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  fdc_in_if.sink      in_if,
  fdc_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [31:0] LimMask =
    (SIZE_BITS >= 32) ? 32'hffff_ffff : 32'((64'd1 << SIZE_BITS) - 64'd1);

  // Configuration registers
  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic [23:0] max_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r       <= '0;
      version_r     <= '0;
      max_payload_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:       magic_r       <= cfg_wdata;
        CFG_VERSION:     version_r     <= cfg_wdata[15:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eob_r;
  logic       room;
  logic       go;

  assign go          = s1_valid_r && room;
  assign in_if.ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.byte_in;
      s1_eob_r  <= in_if.end_of_buffer;
    end
  end

  // Decoder state
  phase_t               phase_r, phase_nxt;
  logic [ConsumedW-1:0] cnt_r, cnt_nxt;
  logic [31:0]          crc_r, crc_nxt;
  logic [7:0]           hdr_r [HdrBytes];
  logic                 hdr_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      crc_r   <= CrcInit;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[cnt_r[HdrIdxW-1:0]] <= s1_byte_r;
    end
  end

  // Header fields (reserved word ignored)
  logic [31:0] h_magic, h_flags, h_size, h_crc, lim;
  logic [15:0] h_version, h_type;
  logic [63:0] h_reqid;
  logic [32:0] consumed_sum;

  assign h_magic   = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign h_version = {hdr_r[5], hdr_r[4]};
  assign h_type    = {hdr_r[7], hdr_r[6]};
  assign h_flags   = {hdr_r[11], hdr_r[10], hdr_r[9], hdr_r[8]};
  assign h_reqid   = {hdr_r[19], hdr_r[18], hdr_r[17], hdr_r[16],
                      hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
  assign h_size    = {hdr_r[23], hdr_r[22], hdr_r[21], hdr_r[20]};
  assign h_crc     = {hdr_r[27], hdr_r[26], hdr_r[25], hdr_r[24]};
  assign lim       = {8'd0, max_payload_r} & LimMask;
  assign consumed_sum = {1'b0, h_size} + 33'(HdrBytes);

  // Per-byte decode: next state and up to two results
  result_t              res0, res1, vres;
  logic [1:0]           push_cnt;
  logic [31:0]          crc_new;
  logic [ConsumedW-1:0] cnt_inc;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    hdr_we    = 1'b0;
    push_cnt  = 2'd0;
    res0      = '0;
    res1      = '0;
    crc_new   = crc_byte(crc_r, s1_byte_r);
    cnt_inc   = cnt_r + ConsumedW'(1);

    // verdict template carrying the header fields
    vres          = '0;
    vres.kind     = KIND_VERDICT;
    vres.msg_type = h_type;
    vres.msg_flags = h_flags;
    vres.msg_id   = h_reqid;
    vres.msg_size = h_size;

    if (go) begin
      case (phase_r)
        PH_HEADER: begin
          hdr_we = 1'b1;
          if (cnt_r[HdrIdxW-1:0] == HdrIdxW'(HdrBytes - 1)) begin
            cnt_nxt = '0;
            if (h_magic != magic_r) begin
              vres.status = ST_BAD_MAGIC;
            end else if (h_version != version_r) begin
              vres.status = ST_BAD_VERSION;
            end else if (h_size > lim) begin
              vres.status = ST_TOO_LARGE;
            end else if (h_size == '0) begin
              vres.status = (h_crc == '0) ? ST_OK : ST_CRC_MISMATCH;
            end else if (s1_eob_r) begin
              vres.status = ST_SHORT_PAYLOAD;
            end
            if (vres.status == ST_OK) begin
              vres.consumed = consumed_sum[ConsumedW-1:0];
            end
            if ((h_magic == magic_r) && (h_version == version_r) && (h_size <= lim) &&
                (h_size != '0) && !s1_eob_r) begin
              phase_nxt = PH_PAYLOAD;
              crc_nxt   = CrcInit;
            end else begin
              phase_nxt     = PH_DONE;
              res0          = vres;
              res0.run_last = 1'b1;
              push_cnt      = 2'd1;
            end
          end else begin
            cnt_nxt = cnt_r + ConsumedW'(1);
            if (s1_eob_r) begin
              // short header: verdict without header fields
              res0          = '0;
              res0.kind     = KIND_VERDICT;
              res0.status   = ST_SHORT_HDR;
              res0.run_last = 1'b1;
              push_cnt      = 2'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          res0.kind         = KIND_PAYLOAD;
          res0.payload_byte = s1_byte_r;
          crc_nxt           = crc_new;
          cnt_nxt           = cnt_inc;
          if ({7'd0, cnt_inc} >= h_size) begin
            vres.status = ((~crc_new) == h_crc) ? ST_OK : ST_CRC_MISMATCH;
            if (vres.status == ST_OK) begin
              vres.consumed = consumed_sum[ConsumedW-1:0];
            end
            res1          = vres;
            res1.run_last = 1'b1;
            push_cnt      = 2'd2;
            phase_nxt     = PH_DONE;
          end else if (s1_eob_r) begin
            vres.status   = ST_SHORT_PAYLOAD;
            res1          = vres;
            res1.run_last = 1'b1;
            push_cnt      = 2'd2;
            phase_nxt     = PH_DONE;
          end else begin
            res0.run_last = 1'b1;
            push_cnt      = 2'd1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      // end of buffer: back to the header phase
      if (s1_eob_r) begin
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        crc_nxt   = CrcInit;
      end
    end
  end

  // Result queue
  result_t head;

  fdc_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_data0 (res0),
    .push_data1 (res1),
    .room       (room),
    .pop_valid  (out_if.valid),
    .pop_ready  (out_if.ready),
    .pop_data   (head)
  );

  assign out_if.kind         = head.kind;
  assign out_if.payload_byte = head.payload_byte;
  assign out_if.status       = head.status;
  assign out_if.msg_type     = head.msg_type;
  assign out_if.msg_flags    = head.msg_flags;
  assign out_if.msg_id       = head.msg_id;
  assign out_if.msg_size     = head.msg_size;
  assign out_if.consumed     = head.consumed;
  assign out_if.run_last     = head.run_last;

endmodule

@@ design/fdc_result_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per request.
module fdc_result_fifo
  import fdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push_data0,
  input  result_t    push_data1,
  output logic       room,
  output logic       pop_valid,
  input  logic       pop_ready,
  output result_t    pop_data
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  result_t         mem [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  // Two free slots are needed for a worst-case item
  assign room      = (count_r <= CntW'(FifoDepth - 2));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push_cnt) - CntW'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_data0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + PtrW'(1)] <= push_data1;
    end
  end

endmodule
